FILE: design/lbpt_pkg.sv
// package for the led blink / pattern timer
// holds command codes, register indexes and the shared struct types; no dependencies
`timescale 1ns / 1ps

package lbpt_pkg;

   localparam int KIND_W  = 2;
   localparam int COUNT_W = 32;
   localparam int PAT_W   = 16;
   localparam int LEN_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // command codes
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DISABLE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ARM     = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH   = 2'd3;

   localparam logic [COUNT_W-1:0] INTERVAL_RESET = 32'd500;
   localparam logic [LEN_W-1:0]   LENGTH_RESET   = 5'd1;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

   typedef struct packed {
      logic [COUNT_W-1:0] interval_ticks;
      logic               run_mode;
      logic [PAT_W-1:0]   pattern_bits;
      logic [LEN_W-1:0]   pattern_length;
   } cfg_type;

   // timer state apart from the step index, whose width follows the pattern depth
   typedef struct packed {
      logic               led_on;
      logic               running;
      logic [COUNT_W-1:0] since_change;
      logic               armed;
      logic [COUNT_W-1:0] since_armed;
      logic [COUNT_W-1:0] armed_limit;
   } state_type;

endpackage

FILE: design/lbpt_if.sv
// valid/ready channel interfaces for the led blink / pattern timer
// depends on lbpt_pkg for field widths
`timescale 1ns / 1ps

interface lbpt_req_if import lbpt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [COUNT_W-1:0] timeout_ticks;

   modport source (output valid, output kind, output timeout_ticks, input ready);
   modport sink   (input valid, input kind, input timeout_ticks, output ready);
endinterface

interface lbpt_rsp_if;
   logic valid;
   logic ready;
   logic led_level;
   logic is_active;
   logic timeout_armed;

   modport source (output valid, output led_level, output is_active, output timeout_armed,
                   input ready);
   modport sink   (input valid, input led_level, input is_active, input timeout_armed,
                   output ready);
endinterface

interface lbpt_csr_if import lbpt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/lbpt_csr_regs.sv
// configuration registers of the led blink / pattern timer
// depends on lbpt_pkg and the lbpt_csr_if interface
`timescale 1ns / 1ps

module lbpt_csr_regs import lbpt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lbpt_csr_if.sink   csr_if,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   logic    wr_fire;

   assign csr_if.ready = 1'b1;
   assign wr_fire      = csr_if.valid && csr_if.ready;
   assign cfg          = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interval_ticks <= INTERVAL_RESET;
         cfg_ff.run_mode       <= 1'b0;
         cfg_ff.pattern_bits   <= '0;
         cfg_ff.pattern_length <= LENGTH_RESET;
      end else if (wr_fire) begin
         unique case (csr_if.index)
            CSR_INTERVAL: cfg_ff.interval_ticks <= csr_if.data[COUNT_W-1:0];
            CSR_RUN_MODE: cfg_ff.run_mode       <= csr_if.data[0];
            CSR_PATTERN:  cfg_ff.pattern_bits   <= csr_if.data[PAT_W-1:0];
            CSR_LENGTH:   cfg_ff.pattern_length <= csr_if.data[LEN_W-1:0];
         endcase
      end
   end

endmodule

FILE: design/lbpt_step.sv
// next-state logic for one command of the led blink / pattern timer
// depends on lbpt_pkg
`timescale 1ns / 1ps

module lbpt_step import lbpt_pkg::*; #(
   parameter int PATTERN_DEPTH = 16,
   parameter int IDX_W         = 4
) (
   input  cfg_type             cfg,
   input  state_type           cur_state,
   input  logic [IDX_W-1:0]    cur_idx,
   input  logic [KIND_W-1:0]   kind,
   input  logic [COUNT_W-1:0]  timeout_ticks,
   output state_type           nxt_state,
   output logic [IDX_W-1:0]    nxt_idx
);

   localparam logic [7:0] DEPTH_L = 8'(PATTERN_DEPTH);

   logic [COUNT_W-1:0] change_inc;
   logic [COUNT_W-1:0] armed_inc;
   logic [7:0]         len_raw;
   logic [7:0]         eff_len;
   logic [IDX_W:0]     idx_plus;
   logic [7:0]         idx_wide;
   logic               pat_bit;

   assign change_inc = (cur_state.since_change == COUNT_MAX) ? COUNT_MAX
                                                             : cur_state.since_change + 1'b1;
   assign armed_inc  = (cur_state.since_armed == COUNT_MAX) ? COUNT_MAX
                                                            : cur_state.since_armed + 1'b1;

   // zero length plays as one step, anything past the depth as the depth
   assign len_raw = 8'(cfg.pattern_length);
   always_comb begin
      eff_len = len_raw;
      if (len_raw == 8'd0)
         eff_len = 8'd1;
      if (len_raw > DEPTH_L)
         eff_len = DEPTH_L;
   end

   assign idx_plus = {1'b0, cur_idx} + 1'b1;
   assign idx_wide = 8'(cur_idx);
   // steps past the stored bits read as off
   assign pat_bit  = (idx_wide < 8'(PAT_W)) ? cfg.pattern_bits[idx_wide[3:0]] : 1'b0;

   always_comb begin
      nxt_state = cur_state;
      nxt_idx   = cur_idx;
      unique case (kind)
         KIND_RESTART: begin
            nxt_state.running      = 1'b1;
            nxt_state.since_change = '0;
            nxt_state.armed        = 1'b0;
            nxt_state.since_armed  = '0;
            nxt_state.led_on       = cfg.run_mode ? cfg.pattern_bits[0] : 1'b1;
            nxt_idx                = '0;
         end
         KIND_DISABLE: begin
            nxt_state.running = 1'b0;
            nxt_state.armed   = 1'b0;
         end
         KIND_ARM: begin
            nxt_state.armed       = 1'b1;
            nxt_state.since_armed = '0;
            nxt_state.armed_limit = timeout_ticks;
         end
         KIND_TICK: begin
            if (cur_state.running) begin
               // led change first, then the timeout
               if (change_inc >= cfg.interval_ticks) begin
                  nxt_state.since_change = '0;
                  if (!cfg.run_mode) begin
                     nxt_state.led_on = !cur_state.led_on;
                  end else begin
                     nxt_state.led_on = pat_bit;
                     nxt_idx = (8'(idx_plus) >= eff_len) ? '0 : idx_plus[IDX_W-1:0];
                  end
               end else begin
                  nxt_state.since_change = change_inc;
               end
               if (cur_state.armed) begin
                  nxt_state.since_armed = armed_inc;
                  if (armed_inc >= cur_state.armed_limit) begin
                     nxt_state.running = 1'b0;
                     nxt_state.armed   = 1'b0;
                  end
               end
            end
         end
      endcase
   end

endmodule

FILE: design/led_blink_pattern_timer_core.sv
// led blink / pattern timer, top level
// a request waits in the input register, then its result in the response register that drives valid
// throughput: one command per cycle unless responses stall; one next-state pass on the timer state
// input register and response register are each one deep: with a response waiting, one more
// request is taken into the input register and then ready drops; reset is synchronous, active
// high, clears the timer state and returns the registers to their defaults
`timescale 1ns / 1ps

module led_blink_pattern_timer_core import lbpt_pkg::*; #(
   parameter int PATTERN_DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   lbpt_req_if.sink  req_if,
   lbpt_rsp_if.source rsp_if,
   lbpt_csr_if.sink  csr_if
);

   localparam int IDX_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

   cfg_type            cfg;

   logic               s1_vld_ff;
   logic [KIND_W-1:0]  s1_kind_ff;
   logic [COUNT_W-1:0] s1_tmo_ff;

   state_type          state_ff;
   state_type          state_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_in;

   logic               rsp_vld_ff;
   logic               rsp_led_ff;
   logic               rsp_active_ff;
   logic               rsp_armed_ff;

   logic               req_fire;
   logic               s2_fire;

   lbpt_csr_regs u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   lbpt_step #(
      .PATTERN_DEPTH (PATTERN_DEPTH),
      .IDX_W         (IDX_W)
   ) u_step (
      .cfg           (cfg),
      .cur_state     (state_ff),
      .cur_idx       (idx_ff),
      .kind          (s1_kind_ff),
      .timeout_ticks (s1_tmo_ff),
      .nxt_state     (state_in),
      .nxt_idx       (idx_in)
   );

   assign s2_fire      = s1_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign req_if.ready = !s1_vld_ff || s2_fire;
   assign req_fire     = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_fire) begin
         s1_vld_ff <= 1'b1;
      end else if (s2_fire) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_if.kind;
         s1_tmo_ff  <= req_if.timeout_ticks;
      end
   end

   // timer state moves as each command leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         idx_ff   <= '0;
      end else if (s2_fire) begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s2_fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         rsp_led_ff    <= state_in.led_on;
         rsp_active_ff <= state_in.running;
         rsp_armed_ff  <= state_in.armed;
      end
   end

   assign rsp_if.valid         = rsp_vld_ff;
   assign rsp_if.led_level     = rsp_led_ff;
   assign rsp_if.is_active     = rsp_active_ff;
   assign rsp_if.timeout_armed = rsp_armed_ff;

`ifndef NO_ASSERTIONS
   a_disable_stops: assert property (@(posedge clock) disable iff (reset)
      s2_fire && s1_kind_ff == KIND_DISABLE |=> !state_ff.running && !state_ff.armed)
      else $error("disable left the timer running or armed");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      s2_fire && s1_kind_ff == KIND_RESTART |=>
         state_ff.running && !state_ff.armed && state_ff.since_change == '0 && idx_ff == '0)
      else $error("restart did not clear the timer state");

   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(s2_fire))
      else $error("response raised without a command passing the step logic");
`endif

endmodule

FILE: tb/testbench.sv
// testbench for led_blink_pattern_timer_core: directed and random commands with register
// changes, every response checked against a timer model kept in the testbench
// depends on lbpt_pkg and the channel interfaces in lbpt_if
`timescale 1ns / 1ps

module testbench;
   import lbpt_pkg::*;

   localparam int PATTERN_DEPTH = 16;
   localparam int LATENCY_WAIT  = 4;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int REPORT_LIMIT  = 100;

   typedef struct packed {
      logic led_level;
      logic is_active;
      logic timeout_armed;
   } led_status_type;

   logic clock;
   logic reset;
   int   cycle_count   = 0;
   int   fail_count    = 0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   hold_left     = 0;

   // local copy of the registers and timer state
   cfg_type        settings;
   state_type      tmr;
   int             step_idx;
   led_status_type expected_status_q[$];

   lbpt_req_if req_if ();
   lbpt_rsp_if rsp_if ();
   lbpt_csr_if csr_if ();

   led_blink_pattern_timer_core #(.PATTERN_DEPTH(PATTERN_DEPTH)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   function automatic void clear_model();
      settings.interval_ticks = INTERVAL_RESET;
      settings.run_mode       = 1'b0;
      settings.pattern_bits   = '0;
      settings.pattern_length = LENGTH_RESET;
      tmr      = '0;
      step_idx = 0;
   endfunction

   function automatic led_status_type advance_timer(input logic [KIND_W-1:0]  kind,
                                                    input logic [COUNT_W-1:0] tmo);
      int steps_used;
      steps_used = (settings.pattern_length == 0) ? 1 :
                   (int'(settings.pattern_length) > PATTERN_DEPTH) ? PATTERN_DEPTH :
                   int'(settings.pattern_length);
      case (kind)
         KIND_RESTART: begin
            tmr.running      = 1'b1;
            tmr.since_change = '0;
            tmr.armed        = 1'b0;
            tmr.since_armed  = '0;
            step_idx         = 0;
            tmr.led_on       = settings.run_mode ? settings.pattern_bits[0] : 1'b1;
         end
         KIND_DISABLE: begin
            tmr.running = 1'b0;
            tmr.armed   = 1'b0;
         end
         KIND_ARM: begin
            tmr.armed       = 1'b1;
            tmr.since_armed = '0;
            tmr.armed_limit = tmo;
         end
         default: begin
            if (tmr.running) begin
               if (tmr.since_change != COUNT_MAX) tmr.since_change++;
               // led change is settled first, then the timeout
               if (tmr.since_change >= settings.interval_ticks) begin
                  tmr.since_change = '0;
                  if (!settings.run_mode) begin
                     tmr.led_on = ~tmr.led_on;
                  end else begin
                     tmr.led_on = (step_idx < PAT_W) ? settings.pattern_bits[step_idx] : 1'b0;
                     step_idx   = (step_idx + 1 >= steps_used) ? 0 : step_idx + 1;
                  end
               end
               if (tmr.armed) begin
                  if (tmr.since_armed != COUNT_MAX) tmr.since_armed++;
                  if (tmr.since_armed >= tmr.armed_limit) begin
                     tmr.running = 1'b0;
                     tmr.armed   = 1'b0;
                  end
               end
            end
         end
      endcase
      return '{led_level: tmr.led_on, is_active: tmr.running, timeout_armed: tmr.armed};
   endfunction

   function automatic cfg_type make_settings(input logic [COUNT_W-1:0] interval,
                                             input logic               mode,
                                             input logic [PAT_W-1:0]   bits,
                                             input logic [LEN_W-1:0]   len);
      return '{interval_ticks: interval, run_mode: mode, pattern_bits: bits,
               pattern_length: len};
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 10) c.interval_ticks = '0;
      else if (pick < 20) c.interval_ticks = COUNT_MAX;
      else if (pick < 28) c.interval_ticks = $urandom();
      else if (pick < 45) c.interval_ticks = $urandom_range(40, 9);
      else c.interval_ticks = $urandom_range(8, 1);
      c.run_mode     = ($urandom_range(99) < 60);
      c.pattern_bits = PAT_W'($urandom());
      pick = $urandom_range(99);
      if (pick < 10) c.pattern_length = '0;
      else if (pick < 20) c.pattern_length = '1;
      else if (pick < 35) c.pattern_length = LEN_W'($urandom_range(30, 17));
      else c.pattern_length = LEN_W'($urandom_range(16, 1));
      return c;
   endfunction

   // all four registers in one burst, unused upper data bits filled with noise
   task automatic load_settings(input cfg_type c);
      logic [CSR_DATA_W-1:0] word [4];
      logic [CSR_IDX_W-1:0]  order [4] = '{CSR_INTERVAL, CSR_RUN_MODE, CSR_PATTERN, CSR_LENGTH};
      word[CSR_INTERVAL]              = c.interval_ticks;
      word[CSR_RUN_MODE]              = $urandom();
      word[CSR_RUN_MODE][0]           = c.run_mode;
      word[CSR_PATTERN]               = $urandom();
      word[CSR_PATTERN][PAT_W-1:0]    = c.pattern_bits;
      word[CSR_LENGTH]                = $urandom();
      word[CSR_LENGTH][LEN_W-1:0]     = c.pattern_length;
      foreach (order[i]) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= order[i];
         csr_if.data  <= word[order[i]];
         do @(posedge clock); while (!csr_if.ready);
      end
      csr_if.valid <= 1'b0;
      settings = c;
   endtask

   task automatic send_command(input logic [KIND_W-1:0] kind, input logic [COUNT_W-1:0] tmo);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.kind          <= kind;
      req_if.timeout_ticks <= tmo;
      do @(posedge clock); while (!req_if.ready);
      expected_status_q.push_back(advance_timer(kind, tmo));
   endtask

   // mostly ticks so that running sequences get deep into the interval and timeout logic
   task automatic send_random_command();
      int                 pick;
      logic [COUNT_W-1:0] tmo;
      pick = $urandom_range(99);
      tmo  = $urandom();
      if (pick < 78) begin
         send_command(KIND_TICK, tmo);
      end else if (pick < 86) begin
         send_command(KIND_RESTART, tmo);
      end else if (pick < 90) begin
         send_command(KIND_DISABLE, tmo);
      end else begin
         pick = $urandom_range(99);
         if (pick < 60) tmo = $urandom_range(40);
         else if (pick < 80) tmo = $urandom_range(600);
         else if (pick < 90) tmo = COUNT_MAX;
         send_command(KIND_ARM, tmo);
      end
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   task automatic test_inactive_and_arm();
      send_command(KIND_TICK, COUNT_MAX);
      send_command(KIND_ARM, '0);
      send_command(KIND_TICK, '0);
      send_command(KIND_RESTART, COUNT_MAX);
      send_command(KIND_TICK, '0);
      send_command(KIND_DISABLE, '0);
      wait_idle();
   endtask

   task automatic test_zero_interval_and_timeout();
      load_settings(make_settings('0, 1'b0, '0, 5'd1));
      send_command(KIND_RESTART, '0);
      send_command(KIND_TICK, '0);
      send_command(KIND_TICK, '0);
      send_command(KIND_ARM, '0);
      send_command(KIND_TICK, '0);
      send_command(KIND_TICK, '0);
      wait_idle();
   endtask

   task automatic test_rearm();
      load_settings(make_settings(32'd1, 1'b0, '0, 5'd1));
      send_command(KIND_RESTART, '0);
      send_command(KIND_ARM, 32'd3);
      send_command(KIND_TICK, '0);
      send_command(KIND_ARM, 32'd2);
      send_command(KIND_TICK, '0);
      send_command(KIND_TICK, '0);
      wait_idle();
   endtask

   task automatic test_pattern_lengths();
      load_settings(make_settings('0, 1'b1, 16'hA5C3, 5'd0));
      send_command(KIND_RESTART, '0);
      send_command(KIND_TICK, '0);
      send_command(KIND_TICK, '0);
      wait_idle();
      load_settings(make_settings('0, 1'b1, 16'hA5C3, 5'd16));
      send_command(KIND_RESTART, '0);
      repeat (5) send_command(KIND_TICK, '0);
      wait_idle();
      // length drops below the current step: that step still plays, then wrap
      load_settings(make_settings('0, 1'b1, 16'h5A3C, 5'd3));
      send_command(KIND_TICK, '0);
      send_command(KIND_TICK, '0);
      wait_idle();
   endtask

   task automatic test_counter_extremes();
      load_settings(make_settings(COUNT_MAX, 1'b1, 16'hFFFF, 5'd31));
      send_command(KIND_RESTART, COUNT_MAX);
      send_command(KIND_ARM, COUNT_MAX);
      send_command(KIND_TICK, COUNT_MAX);
      send_command(KIND_TICK, '0);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
      int sent;
      int chunk;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         load_settings(random_settings());
         chunk = $urandom_range(90, 40);
         // sometimes carry the old run over a change of mode or pattern
         if ($urandom_range(99) < 70) send_command(KIND_RESTART, $urandom());
         repeat (chunk) send_random_command();
         wait_idle();
         sent += chunk;
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      load_settings(make_settings(32'd2, 1'b0, '0, 5'd1));
      send_command(KIND_RESTART, '0);
      hold_left = 300;
      repeat (70) send_random_command();
      wait_idle();
   endtask

   // response side: random stalls, or a long hold-off when asked
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_responses
      led_status_type got;
      led_status_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.led_level, rsp_if.is_active, rsp_if.timeout_armed};
         if (expected_status_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t: response with none expected, actual led=%b active=%b armed=%b",
                        $time, got.led_level, got.is_active, got.timeout_armed);
         end else begin
            want = expected_status_q.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: expected led=%b active=%b armed=%b, actual led=%b active=%b armed=%b",
                           $time, want.led_level, want.is_active, want.timeout_armed,
                           got.led_level, got.is_active, got.timeout_armed);
            end
         end
      end
   end

   initial begin
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.kind          <= KIND_TICK;
      req_if.timeout_ticks <= '0;
      csr_if.valid         <= 1'b0;
      csr_if.index         <= CSR_INTERVAL;
      csr_if.data          <= '0;
      clear_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_inactive_and_arm();
      test_zero_interval_and_timeout();
      test_rearm();
      test_pattern_lengths();
      test_counter_extremes();
      test_random_traffic(0, 0, 220);
      test_random_traffic(84, 0, 220);
      test_random_traffic(0, 84, 220);
      test_random_traffic(21, 21, 220);
      test_backpressure();

      wait_idle();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: led_blink_pattern_timer_core.f
design/lbpt_pkg.sv
design/lbpt_if.sv
design/lbpt_csr_regs.sv
design/lbpt_step.sv
design/led_blink_pattern_timer_core.sv
tb/testbench.sv
